/* sv/pse_pkg.sv */
// ---------------------------------------------------------------------------
// pse_pkg
// Shared types and constants for the prefix expression stack evaluator.
// ---------------------------------------------------------------------------
package pse_pkg;

    localparam int DEFAULT_STACK_DEPTH = 128;
    localparam int WORD_W = 32;

    // operator codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_POW = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_DIVZERO   = 3'd3;
    localparam logic [2:0] ST_ZERONEG   = 3'd4;

    // classified token as held in the queue between front and back
    typedef struct packed {
        logic        is_op;
        logic        known_op;
        logic [31:0] value;
        logic [2:0]  code;
        logic        last;
    } pse_token_t;

endpackage

/* sv/pse_front.sv */
// ---------------------------------------------------------------------------
// pse_front
// Accepts tokens, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module pse_front
    import pse_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic signed [31:0] operand_value,
    input  logic [2:0]         operator_code,
    input  logic               last_token,
    output logic               tok_valid,
    output pse_token_t         tok,
    input  logic               tok_take
);

    pse_token_t q_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] count_reg;
    pse_token_t new_tok;
    logic       push, pop;

    // classify the incoming token
    always_comb
    begin
        new_tok.is_op    = kind;
        new_tok.known_op = (operator_code <= OP_POW);
        new_tok.value    = operand_value;
        new_tok.code     = operator_code;
        new_tok.last     = last_token;
    end

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign tok_valid = (count_reg != 2'd0);
    assign pop       = tok_valid && tok_take;
    assign tok       = q_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_tok;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* sv/pse_divider.sv */
// ---------------------------------------------------------------------------
// pse_divider
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pse_divider
    import pse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted  = {rem_reg, quo_reg[31]};
    assign trial    = shifted - {1'b0, dvs_reg};
    assign quotient = quo_reg;

    // iterate one bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

endmodule

/* sv/pse_back.sv */
// ---------------------------------------------------------------------------
// pse_back
// Executes tokens against the operand stack and emits expression results.
// ---------------------------------------------------------------------------
module pse_back
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tok_valid,
    input  pse_token_t         tok,
    output logic               tok_take,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_value,
    output logic [2:0]         status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD_A, S_RD_B, S_EXEC, S_MUL, S_DIV, S_DIVW,
        S_POW, S_POWM, S_WRITE, S_FINISH, S_OUT
    } state_t;

    state_t      state_reg;
    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rd_data_reg;
    logic [DW-1:0] depth_reg;
    logic [2:0]  err_reg;
    logic [31:0] a_reg, b_reg, r_reg, acc_reg, sq_reg;
    logic [5:0]  pcnt_reg;
    logic        neg_reg, sqphase_reg;
    pse_token_t  cur_reg;
    logic [31:0] top_reg;
    logic        top_ok_reg;

    // memory ports
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_data;

    // multiplier with registered product
    logic [31:0] mul_x, mul_y, prod_reg;

    // divider
    logic        div_start, div_done;
    logic [31:0] div_q, ma, mb;

    assign ma = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign mb = b_reg[31] ? (32'd0 - b_reg) : b_reg;

    pse_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ma),
        .divisor  (mb),
        .done     (div_done),
        .quotient (div_q)
    );

    // memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_x * mul_y;
    end

    assign tok_take  = (state_reg == S_IDLE) && tok_valid;
    assign div_start = (state_reg == S_DIV);
    assign out_valid = (state_reg == S_OUT);

    // port and multiplier steering
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = cur_reg.value;
        rd_addr = AW'(depth_reg - DW'(1));
        mul_x   = a_reg;
        mul_y   = b_reg;
        if (state_reg == S_RD_A || state_reg == S_RD_B)
        begin
            rd_addr = AW'(depth_reg - DW'(2));
        end
        if (state_reg == S_POW || state_reg == S_POWM)
        begin
            mul_x = sqphase_reg ? sq_reg : acc_reg;
            mul_y = sq_reg;
        end
        if (state_reg == S_IDLE && tok_valid && err_reg == ST_OK && !tok.is_op
            && depth_reg < DW'(STACK_DEPTH))
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(depth_reg);
            wr_data = tok.value;
        end
        if (state_reg == S_WRITE)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(depth_reg - DW'(2));
            wr_data = r_reg;
        end
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            depth_reg  <= '0;
            err_reg    <= ST_OK;
            top_ok_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (tok_valid)
                    begin
                        cur_reg <= tok;
                        if (err_reg != ST_OK)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else if (!tok.is_op)
                        begin
                            if (depth_reg >= DW'(STACK_DEPTH))
                            begin
                                err_reg <= ST_OVERFLOW;
                            end
                            else
                            begin
                                depth_reg  <= depth_reg + DW'(1);
                                top_reg    <= tok.value;
                                top_ok_reg <= 1'b1;
                            end
                            state_reg <= S_FINISH;
                        end
                        else if (!tok.known_op)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else if (depth_reg < DW'(2))
                        begin
                            err_reg   <= ST_UNDERFLOW;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_RD_A;
                        end
                    end
                end
                S_RD_A:
                begin
                    // top read issued in S_IDLE arrives now; B address issued
                    a_reg     <= rd_data_reg;
                    state_reg <= S_RD_B;
                end
                S_RD_B:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    b_reg     <= rd_data_reg;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // operands both valid here
                    unique case (cur_reg.code)
                        OP_ADD:
                        begin
                            r_reg     <= a_reg + b_reg;
                            state_reg <= S_WRITE;
                        end
                        OP_SUB:
                        begin
                            r_reg     <= a_reg - b_reg;
                            state_reg <= S_WRITE;
                        end
                        OP_MUL:
                        begin
                            state_reg <= S_DIVW;
                        end
                        OP_DIV:
                        begin
                            if (b_reg == 32'd0)
                            begin
                                err_reg   <= ST_DIVZERO;
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                neg_reg   <= a_reg[31] ^ b_reg[31];
                                state_reg <= S_DIV;
                            end
                        end
                        default:
                        begin
                            if (b_reg[31])
                            begin
                                if (a_reg == 32'd0)
                                begin
                                    err_reg   <= ST_ZERONEG;
                                    state_reg <= S_FINISH;
                                end
                                else
                                begin
                                    if (a_reg == 32'd1)
                                        r_reg <= 32'd1;
                                    else if (a_reg == 32'hFFFF_FFFF)
                                        r_reg <= b_reg[0] ? 32'hFFFF_FFFF : 32'd1;
                                    else
                                        r_reg <= 32'd0;
                                    state_reg <= S_WRITE;
                                end
                            end
                            else
                            begin
                                acc_reg     <= 32'd1;
                                sq_reg      <= a_reg;
                                pcnt_reg    <= 6'd0;
                                sqphase_reg <= 1'b0;
                                state_reg   <= S_POW;
                            end
                        end
                    endcase
                end
                S_DIV:
                begin
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (cur_reg.code == OP_MUL)
                    begin
                        r_reg     <= prod_reg;
                        state_reg <= S_WRITE;
                    end
                    else if (div_done)
                    begin
                        r_reg     <= neg_reg ? (32'd0 - div_q) : div_q;
                        state_reg <= S_WRITE;
                    end
                end
                S_POW:
                begin
                    // multiply issued on acc or sq; the product is registered and read in S_POWM
                    state_reg <= S_POWM;
                end
                S_POWM:
                begin
                    if (b_reg == 32'd0)
                    begin
                        // zero exponent gives one
                        r_reg     <= 32'd1;
                        state_reg <= S_WRITE;
                    end
                    else if (!sqphase_reg)
                    begin
                        if (b_reg[pcnt_reg[4:0]])
                        begin
                            acc_reg <= prod_reg;
                        end
                        sqphase_reg <= 1'b1;
                        state_reg   <= S_POW;
                    end
                    else
                    begin
                        sq_reg      <= prod_reg;
                        sqphase_reg <= 1'b0;
                        if (pcnt_reg == 6'd30 || (b_reg >> (pcnt_reg + 6'd1)) == 32'd0)
                        begin
                            r_reg     <= acc_reg;
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            pcnt_reg  <= pcnt_reg + 6'd1;
                            state_reg <= S_POW;
                        end
                    end
                end
                S_WRITE:
                begin
                    depth_reg  <= depth_reg - DW'(1);
                    top_reg    <= r_reg;
                    state_reg  <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (cur_reg.last)
                    begin
                        if (err_reg == ST_OK && depth_reg == '0)
                        begin
                            err_reg <= ST_UNDERFLOW;
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        depth_reg <= '0;
                        err_reg   <= ST_OK;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign status       = err_reg;
    assign result_value = (err_reg == ST_OK && top_ok_reg) ? top_reg : 32'sd0;

endmodule

/* sv/prefix_expression_stack_evaluator_unit.sv */
// ---------------------------------------------------------------------------
// prefix_expression_stack_evaluator_unit
// Top level: token queue front end and stack execution back end.
// ---------------------------------------------------------------------------
// Tokens of a prefix expression enter right to left. A two-entry queue takes
// tokens while the back end works. Divide runs on the restoring divider, one
// quotient bit per cycle; power makes two passes of the shared 32x32
// multiplier per exponent bit. One result (value and status) is offered
// after the token marked last_token.
module prefix_expression_stack_evaluator_unit
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic signed [31:0] operand_value,
    input  logic [2:0]         operator_code,
    input  logic               last_token,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_value,
    output logic [2:0]         status
);

    pse_token_t tok;
    logic       tok_valid, tok_take;

    pse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .operand_value (operand_value),
        .operator_code (operator_code),
        .last_token    (last_token),
        .tok_valid     (tok_valid),
        .tok           (tok),
        .tok_take      (tok_take)
    );

    pse_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (tok_valid),
        .tok          (tok),
        .tok_take     (tok_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .status       (status)
    );

endmodule
